// ----- rtl/core/qs_pkg.sv -----
`default_nettype none

package qs_pkg;

   // sizing
   localparam int MAX_KEYS    = 64;
   localparam int KEY_WIDTH   = 32;
   localparam int IO_KEY_BITS = 32;

   localparam int IDX_WIDTH   = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1;
   localparam int CNT_WIDTH   = $clog2(MAX_KEYS + 1);

   // pending ranges are disjoint and hold two or more keys each
   localparam int STACK_DEPTH = MAX_KEYS / 2;
   localparam int STK_AWIDTH  = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
   localparam int SP_WIDTH    = $clog2(STACK_DEPTH + 1);

   // configuration port
   localparam int CSR_ADDR_WIDTH = 8;
   localparam int CSR_DATA_WIDTH = 32;

   localparam logic [CSR_ADDR_WIDTH-1:0] CSR_DESCENDING  = CSR_ADDR_WIDTH'(0);
   localparam logic [CSR_ADDR_WIDTH-1:0] CSR_SIGNED_KEYS = CSR_ADDR_WIDTH'(1);

   typedef logic [KEY_WIDTH-1:0]   key_type;
   typedef logic [IO_KEY_BITS-1:0] io_key_type;
   typedef logic [IDX_WIDTH-1:0]   idx_type;
   typedef logic [CNT_WIDTH-1:0]   cnt_type;
   typedef logic [SP_WIDTH-1:0]    sp_type;
   typedef logic [STK_AWIDTH-1:0]  stk_addr_type;

   typedef struct packed {
      logic descending;
      logic signed_keys;
   } cfg_type;

   typedef struct packed {
      idx_type lo;
      idx_type hi;
   } range_type;

   typedef struct packed {
      logic    en;
      idx_type addr;
      key_type data;
   } store_wr_type;

   typedef enum logic [3:0] {
      ST_LOAD,
      ST_INIT,
      ST_POP,
      ST_RANGE,
      ST_PIVOT,
      ST_RD_I,
      ST_CMP_I,
      ST_RD_J,
      ST_CMP_J,
      ST_SWAP_I,
      ST_SWAP_J,
      ST_FIN_RD,
      ST_FIN_LO,
      ST_FIN_J,
      ST_EMIT_RD,
      ST_EMIT
   } state_type;

   function automatic key_type fit_key(io_key_type k);
      logic [63:0] w;
      w = 64'(k);
      return w[KEY_WIDTH-1:0];
   endfunction

   function automatic io_key_type out_key(key_type k);
      logic [63:0] w;
      w = 64'(k);
      return w[IO_KEY_BITS-1:0];
   endfunction

endpackage

`default_nettype wire

// ----- rtl/core/qs_if.sv -----
`default_nettype none

interface qs_req_if;
   logic                  valid;
   logic                  ready;
   qs_pkg::io_key_type    key;
   logic                  last;

   modport source (output valid, output key, output last, input ready);
   modport sink   (input valid, input key, input last, output ready);
endinterface

interface qs_rsp_if;
   logic                  valid;
   logic                  ready;
   qs_pkg::io_key_type    sorted_key;
   logic                  last_out;
   logic                  overflow;

   modport source (output valid, output sorted_key, output last_out, output overflow,
                   input ready);
   modport sink   (input valid, input sorted_key, input last_out, input overflow,
                   output ready);
endinterface

interface qs_csr_if;
   logic                                 valid;
   logic                                 ready;
   logic [qs_pkg::CSR_ADDR_WIDTH-1:0]    index;
   logic [qs_pkg::CSR_DATA_WIDTH-1:0]    data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/quicksort_engine.sv -----
`default_nettype none

// Channel   Dir  Payload                              Beat
// req_if    in   key[31:0], last                      valid & ready
// rsp_if    out  sorted_key[31:0], last_out, overflow valid & ready
// csr_if    in   index[7:0], data[31:0]               valid & ready (always ready)
//
// The last key starts an in-place quicksort on the key store and one rank
// comparator: a scan step reads then compares, a swap writes both keys, and
// each range adds a pop, a pivot read and a final pivot write. After a
// first read, sorted keys stream out at one beat per cycle while rsp_if.ready
// is high. Synchronous reset clears state, counts, flags and config only.
// req_if.ready is low from the last key until the final result is taken;
// a stalled result holds its beat and its read address.
module quicksort_engine (
   input  logic          clock,
   input  logic          reset,
   qs_req_if.sink        req_if,
   qs_rsp_if.source      rsp_if,
   qs_csr_if.sink        csr_if
);

   qs_pkg::state_type state_ff, state_in;
   qs_pkg::cnt_type   count_ff, count_in;
   logic              ovf_ff, ovf_in;
   qs_pkg::sp_type    sp_ff, sp_in;
   qs_pkg::idx_type   lo_ff, lo_in, hi_ff, hi_in;
   qs_pkg::idx_type   i_ff, i_in, j_ff, j_in, k_ff, k_in;
   qs_pkg::key_type   piv_ff, piv_in, ki_ff, ki_in, kj_ff, kj_in;
   qs_pkg::cfg_type   cfg_ff, cfg_in;

   qs_pkg::store_wr_type   st_wr;
   qs_pkg::idx_type        st_raddr;
   qs_pkg::key_type        st_rdata;

   logic                   stk_we;
   qs_pkg::stk_addr_type   stk_waddr, stk_raddr;
   qs_pkg::range_type      stk_wdata, stk_rdata_ff;
   qs_pkg::range_type      stack_mem [qs_pkg::STACK_DEPTH];

   logic                   le;
   logic                   req_acc, rsp_acc;
   logic [qs_pkg::IDX_WIDTH:0] j_x, lo_x, hi_x;
   qs_pkg::sp_type         sp_dec;
   logic                   emit_last;

   assign req_acc   = req_if.valid & req_if.ready;
   assign rsp_acc   = rsp_if.valid & rsp_if.ready;
   assign j_x       = {1'b0, j_ff};
   assign lo_x      = {1'b0, lo_ff};
   assign hi_x      = {1'b0, hi_ff};
   assign sp_dec    = sp_ff - qs_pkg::sp_type'(1);
   assign emit_last = ((qs_pkg::CNT_WIDTH'(k_ff) + qs_pkg::CNT_WIDTH'(1)) == count_ff);

   // configuration
   assign csr_if.ready = 1'b1;
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_if.valid) begin
         unique case (csr_if.index)
            qs_pkg::CSR_DESCENDING:  cfg_in.descending  = csr_if.data[0];
            qs_pkg::CSR_SIGNED_KEYS: cfg_in.signed_keys = csr_if.data[0];
            default: ;
         endcase
      end
   end

   qs_cmp u_cmp (
      .cfg    (cfg_ff),
      .a      (st_rdata),
      .b      (piv_ff),
      .a_le_b (le)
   );

   qs_store u_store (
      .clock (clock),
      .wr    (st_wr),
      .raddr (st_raddr),
      .rdata (st_rdata)
   );

   // range stack
   always_ff @(posedge clock) begin
      if (stk_we) begin
         stack_mem[stk_waddr] <= stk_wdata;
      end
      stk_rdata_ff <= stack_mem[stk_raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= qs_pkg::ST_LOAD;
         count_ff <= '0;
         ovf_ff   <= 1'b0;
         sp_ff    <= '0;
         cfg_ff   <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         ovf_ff   <= ovf_in;
         sp_ff    <= sp_in;
         cfg_ff   <= cfg_in;
      end
   end

   always_ff @(posedge clock) begin
      lo_ff  <= lo_in;
      hi_ff  <= hi_in;
      i_ff   <= i_in;
      j_ff   <= j_in;
      k_ff   <= k_in;
      piv_ff <= piv_in;
      ki_ff  <= ki_in;
      kj_ff  <= kj_in;
   end

   always_comb begin
      state_in  = state_ff;
      count_in  = count_ff;
      ovf_in    = ovf_ff;
      sp_in     = sp_ff;
      lo_in     = lo_ff;
      hi_in     = hi_ff;
      i_in      = i_ff;
      j_in      = j_ff;
      k_in      = k_ff;
      piv_in    = piv_ff;
      ki_in     = ki_ff;
      kj_in     = kj_ff;
      st_wr     = '0;
      st_raddr  = '0;
      stk_we    = 1'b0;
      stk_waddr = sp_ff[qs_pkg::STK_AWIDTH-1:0];
      stk_wdata = '0;
      stk_raddr = sp_dec[qs_pkg::STK_AWIDTH-1:0];
      req_if.ready = 1'b0;
      rsp_if.valid = 1'b0;

      unique case (state_ff)
         qs_pkg::ST_LOAD: begin
            req_if.ready = 1'b1;
            if (req_acc) begin
               if (count_ff < qs_pkg::CNT_WIDTH'(qs_pkg::MAX_KEYS)) begin
                  st_wr.en   = 1'b1;
                  st_wr.addr = count_ff[qs_pkg::IDX_WIDTH-1:0];
                  st_wr.data = qs_pkg::fit_key(req_if.key);
                  count_in   = count_ff + qs_pkg::cnt_type'(1);
               end else begin
                  ovf_in = 1'b1;
               end
               if (req_if.last) begin
                  state_in = qs_pkg::ST_INIT;
               end
            end
         end
         qs_pkg::ST_INIT: begin
            k_in  = '0;
            sp_in = '0;
            if (count_ff >= qs_pkg::CNT_WIDTH'(2)) begin
               stk_we       = 1'b1;
               stk_waddr    = '0;
               stk_wdata.lo = '0;
               stk_wdata.hi = qs_pkg::IDX_WIDTH'(count_ff - qs_pkg::cnt_type'(1));
               sp_in        = qs_pkg::sp_type'(1);
               state_in     = qs_pkg::ST_POP;
            end else begin
               state_in = qs_pkg::ST_EMIT_RD;
            end
         end
         qs_pkg::ST_POP: begin
            sp_in    = sp_dec;
            state_in = qs_pkg::ST_RANGE;
         end
         qs_pkg::ST_RANGE: begin
            lo_in    = stk_rdata_ff.lo;
            hi_in    = stk_rdata_ff.hi;
            i_in     = stk_rdata_ff.lo;
            j_in     = stk_rdata_ff.hi;
            st_raddr = stk_rdata_ff.lo;
            state_in = qs_pkg::ST_PIVOT;
         end
         qs_pkg::ST_PIVOT: begin
            piv_in   = st_rdata;
            state_in = qs_pkg::ST_RD_I;
         end
         qs_pkg::ST_RD_I: begin
            st_raddr = i_ff;
            state_in = (i_ff < j_ff) ? qs_pkg::ST_CMP_I : qs_pkg::ST_RD_J;
         end
         qs_pkg::ST_CMP_I: begin
            st_raddr = i_ff;
            if (le) begin
               i_in     = i_ff + qs_pkg::idx_type'(1);
               state_in = qs_pkg::ST_RD_I;
            end else begin
               ki_in    = st_rdata;
               state_in = qs_pkg::ST_RD_J;
            end
         end
         qs_pkg::ST_RD_J: begin
            st_raddr = j_ff;
            // j at lo leaves i >= j, so no swap can follow
            state_in = (j_ff > lo_ff) ? qs_pkg::ST_CMP_J : qs_pkg::ST_FIN_RD;
         end
         qs_pkg::ST_CMP_J: begin
            st_raddr = j_ff;
            if (!le) begin
               j_in     = j_ff - qs_pkg::idx_type'(1);
               state_in = qs_pkg::ST_RD_J;
            end else begin
               kj_in    = st_rdata;
               state_in = (i_ff < j_ff) ? qs_pkg::ST_SWAP_I : qs_pkg::ST_FIN_RD;
            end
         end
         qs_pkg::ST_SWAP_I: begin
            st_wr.en   = 1'b1;
            st_wr.addr = i_ff;
            st_wr.data = kj_ff;
            state_in   = qs_pkg::ST_SWAP_J;
         end
         qs_pkg::ST_SWAP_J: begin
            st_wr.en   = 1'b1;
            st_wr.addr = j_ff;
            st_wr.data = ki_ff;
            state_in   = qs_pkg::ST_RD_I;
         end
         qs_pkg::ST_FIN_RD: begin
            st_raddr = j_ff;
            state_in = qs_pkg::ST_FIN_LO;
         end
         qs_pkg::ST_FIN_LO: begin
            st_wr.en   = 1'b1;
            st_wr.addr = lo_ff;
            st_wr.data = st_rdata;
            if (j_x > lo_x + 1'b1) begin
               stk_we       = 1'b1;
               stk_wdata.lo = lo_ff;
               stk_wdata.hi = j_ff - qs_pkg::idx_type'(1);
               sp_in        = sp_ff + qs_pkg::sp_type'(1);
            end
            state_in = qs_pkg::ST_FIN_J;
         end
         qs_pkg::ST_FIN_J: begin
            st_wr.en   = 1'b1;
            st_wr.addr = j_ff;
            st_wr.data = piv_ff;
            if (j_x + 1'b1 < hi_x) begin
               stk_we       = 1'b1;
               stk_wdata.lo = j_ff + qs_pkg::idx_type'(1);
               stk_wdata.hi = hi_ff;
               sp_in        = sp_ff + qs_pkg::sp_type'(1);
            end
            state_in = (sp_in != '0) ? qs_pkg::ST_POP : qs_pkg::ST_EMIT_RD;
         end
         qs_pkg::ST_EMIT_RD: begin
            st_raddr = k_ff;
            state_in = qs_pkg::ST_EMIT;
         end
         qs_pkg::ST_EMIT: begin
            rsp_if.valid = 1'b1;
            st_raddr     = k_ff;
            if (rsp_acc) begin
               // fetch the next key now so it is ready on the following beat
               st_raddr = k_ff + qs_pkg::idx_type'(1);
               k_in     = k_ff + qs_pkg::idx_type'(1);
               if (emit_last) begin
                  count_in = '0;
                  ovf_in   = 1'b0;
                  sp_in    = '0;
                  state_in = qs_pkg::ST_LOAD;
               end
            end
         end
         default: state_in = qs_pkg::ST_LOAD;
      endcase
   end

   assign rsp_if.sorted_key = qs_pkg::out_key(st_rdata);
   assign rsp_if.last_out   = emit_last;
   assign rsp_if.overflow   = ovf_ff;

`ifndef SYNTH
   a_no_accept_while_emitting: assert property (@(posedge clock) disable iff (reset)
      req_if.ready |-> !rsp_if.valid)
      else $error("input accepted while results pending");

   a_stack_bounded: assert property (@(posedge clock) disable iff (reset)
      sp_ff <= qs_pkg::sp_type'(qs_pkg::STACK_DEPTH))
      else $error("range stack overrun");

   a_scan_i_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == qs_pkg::ST_CMP_I) |-> (i_ff < j_ff) && (i_ff >= lo_ff))
      else $error("left scan pointer out of range");

   a_scan_j_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == qs_pkg::ST_CMP_J) |-> (j_ff > lo_ff) && (j_ff <= hi_ff))
      else $error("right scan pointer out of range");

   a_batch_cleared: assert property (@(posedge clock) disable iff (reset)
      rsp_acc && rsp_if.last_out |=> (count_ff == '0) && !ovf_ff)
      else $error("batch state not cleared after final result");
`endif

endmodule

`default_nettype wire

// ----- rtl/core/qs_cmp.sv -----
`default_nettype none

// Rank compare shared by both partition scans: a_le_b when key a sorts
// no later than key b under the current order and signedness.
module qs_cmp (
   input  var qs_pkg::cfg_type cfg,
   input  var qs_pkg::key_type a,
   input  var qs_pkg::key_type b,
   output logic                a_le_b
);

   function automatic qs_pkg::key_type rank_of(qs_pkg::key_type k, qs_pkg::cfg_type c);
      qs_pkg::key_type r;
      r = k;
      if (c.signed_keys) begin
         r[qs_pkg::KEY_WIDTH-1] = ~r[qs_pkg::KEY_WIDTH-1];
      end
      if (c.descending) begin
         r = ~r;
      end
      return r;
   endfunction

   assign a_le_b = (rank_of(a, cfg) <= rank_of(b, cfg));

endmodule

`default_nettype wire

// ----- rtl/core/qs_store.sv -----
`default_nettype none

// Key store: one write port, one read port, registered read data.
module qs_store (
   input  logic                    clock,
   input  var qs_pkg::store_wr_type wr,
   input  var qs_pkg::idx_type     raddr,
   output qs_pkg::key_type         rdata
);

   qs_pkg::key_type mem [qs_pkg::MAX_KEYS];
   qs_pkg::key_type rdata_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire
